// ===== rtl/core/htoi_pkg.sv =====
// ----------------------------------------------------------------------------
// htoi_pkg
// Shared types, character codes and result codes for the hex text converter.
// ----------------------------------------------------------------------------
package htoi_pkg;

	// Character codes
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	// Result codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_EMPTY     = 3'd1;
	localparam logic [2:0] ERR_SIGN_ONLY = 3'd2;
	localparam logic [2:0] ERR_PFX_ONLY  = 3'd3;
	localparam logic [2:0] ERR_PFX_LEAD  = 3'd4;
	localparam logic [2:0] ERR_NO_DIGITS = 3'd5;
	localparam logic [2:0] ERR_NON_HEX   = 3'd6;

	// Widths
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned NUM_W   = 32;
	localparam int unsigned ERR_W   = 3;
	localparam int unsigned OUT_W   = 40;

	// Classified input item passed from front to back
	typedef struct packed {
		logic       is_end;
		logic       is_sign;
		logic       is_minus;
		logic       is_x;
		logic       is_zero;
		logic       is_hex;
		logic [3:0] digit;
	} cls_t;

	// Classify one input item
	function automatic cls_t classify(input logic kind, input logic [7:0] c);
		cls_t r;
		r          = '0;
		r.is_end   = kind;
		r.is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
		r.is_minus = (c == CH_MINUS);
		r.is_x     = (c == CH_LX) || (c == CH_UX);
		r.is_zero  = (c == CH_0);
		if (c inside {[CH_0:CH_9]}) begin
			r.is_hex = 1'b1;
			r.digit  = 4'(c - CH_0);
		end else if (c inside {[CH_LA:CH_LF]}) begin
			r.is_hex = 1'b1;
			r.digit  = 4'(c - CH_LA + HEX_TEN);
		end else if (c inside {[CH_UA:CH_UF]}) begin
			r.is_hex = 1'b1;
			r.digit  = 4'(c - CH_UA + HEX_TEN);
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/htoi_front.sv =====
// ----------------------------------------------------------------------------
// htoi_front
// Accepts input transfers, classifies each character and registers it
// for the item queue.
// ----------------------------------------------------------------------------
module htoi_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // char_code[7:0]
	input  logic                        s_tuser,   // kind
	output logic                        cls_vld,
	output htoi_pkg::cls_t              cls,
	input  logic                        cls_rdy
);
	import htoi_pkg::*;

	logic vld_s1;
	cls_t cls_s1;

	// Take a new item whenever the stage is empty or drains this cycle
	assign s_tready = !vld_s1 || cls_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	// Hold the classified item until the queue takes it
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cls_s1 <= classify(s_tuser, s_tdata);
		end
	end

	assign cls_vld = vld_s1;
	assign cls     = cls_s1;

endmodule

// ===== rtl/core/htoi_queue.sv =====
// ----------------------------------------------------------------------------
// htoi_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module htoi_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push_vld,
	output logic                        push_rdy,
	input  htoi_pkg::cls_t              push_item,
	output logic                        pop_vld,
	input  logic                        pop_rdy,
	output htoi_pkg::cls_t              pop_item
);
	import htoi_pkg::*;

	cls_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_rdy = (cnt_q != 2'd2);
	assign pop_vld  = (cnt_q != 2'd0);
	assign push     = push_vld && push_rdy;
	assign pop      = pop_vld && pop_rdy;
	assign pop_item = mem_q[rd_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/core/htoi_back.sv =====
// ----------------------------------------------------------------------------
// htoi_back
// Carries out classified items: tracks sign and prefix position, accumulates
// hex digits and, on end of string, registers the value and result code.
// ----------------------------------------------------------------------------
module htoi_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_vld,
	output logic                        item_rdy,
	input  htoi_pkg::cls_t              item,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [htoi_pkg::OUT_W-1:0]  m_tdata    // number[31:0], error_code[34:32]
);
	import htoi_pkg::*;

	// String state
	logic [1:0]       cnt_q;
	logic [NUM_W-1:0] acc_q;
	logic             bad_q;
	logic             beyond_q;

	// Flags of the first three characters
	logic h0_sign_q, h0_minus_q, h0_zero_q, h1_x_q, h1_zero_q, h2_x_q;

	// Output register
	logic             out_vld_q;
	logic [NUM_W-1:0] num_q;
	logic [ERR_W-1:0] err_q;

	logic             out_free;
	logic             pop;
	logic             pop_char;
	logic             pop_end;
	logic             signed0;
	logic             skip;
	logic [NUM_W-1:0] acc_nxt;
	logic             pfx_found;
	logic [1:0]       end_i;
	logic             no_digits;
	logic [ERR_W-1:0] err_nxt;
	logic [NUM_W-1:0] num_nxt;

	assign out_free = !out_vld_q || m_tready;
	assign item_rdy = !item.is_end || out_free;
	assign pop      = item_vld && item_rdy;
	assign pop_char = pop && !item.is_end;
	assign pop_end  = pop && item.is_end;

	// Decide whether a character is a digit position
	always_comb begin
		signed0 = (cnt_q != 2'd0) && h0_sign_q;
		skip    = ((cnt_q == 2'd0) && item.is_sign)
			|| ((cnt_q == 2'd1) && !signed0 && item.is_x)
			|| ((cnt_q == 2'd2) && signed0 && item.is_x);
		acc_nxt = {acc_q[NUM_W-5:0], 4'b0000} + {{(NUM_W-4){1'b0}}, item.digit};
	end

	// Classify the finished string
	always_comb begin
		if (h0_sign_q) begin
			pfx_found = (cnt_q == 2'd3) && h2_x_q;
		end else begin
			pfx_found = (cnt_q >= 2'd2) && h1_x_q;
		end
		end_i = {pfx_found, 1'b0} + {1'b0, h0_sign_q};
		if (cnt_q != 2'd3) begin
			no_digits = (cnt_q == end_i);
		end else begin
			no_digits = (end_i == 2'd3) && !beyond_q;
		end
		num_nxt = '0;
		if (cnt_q == 2'd0) begin
			err_nxt = ERR_EMPTY;
		end else if (h0_sign_q && (cnt_q == 2'd1)) begin
			err_nxt = ERR_SIGN_ONLY;
		end else if (!h0_sign_q && pfx_found && (cnt_q == 2'd2)) begin
			err_nxt = ERR_PFX_ONLY;
		end else if (pfx_found && !(h0_sign_q ? h1_zero_q : h0_zero_q)) begin
			err_nxt = ERR_PFX_LEAD;
		end else if (no_digits) begin
			err_nxt = ERR_NO_DIGITS;
		end else if (bad_q) begin
			err_nxt = ERR_NON_HEX;
		end else begin
			err_nxt = ERR_NONE;
			num_nxt = h0_minus_q ? (NUM_W'(0) - acc_q) : acc_q;
		end
	end

	// Advance string state; clear it after end of string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			acc_q    <= '0;
			bad_q    <= 1'b0;
			beyond_q <= 1'b0;
		end else if (pop_end) begin
			cnt_q    <= 2'd0;
			acc_q    <= '0;
			bad_q    <= 1'b0;
			beyond_q <= 1'b0;
		end else if (pop_char) begin
			if (!skip) begin
				if (item.is_hex) acc_q <= acc_nxt;
				else             bad_q <= 1'b1;
			end
			if (cnt_q != 2'd3) cnt_q    <= cnt_q + 2'd1;
			else               beyond_q <= 1'b1;
		end
	end

	// Record flags of the leading characters
	always_ff @(posedge clk) begin
		if (pop_char) begin
			case (cnt_q)
				2'd0: begin
					h0_sign_q  <= item.is_sign;
					h0_minus_q <= item.is_minus;
					h0_zero_q  <= item.is_zero;
				end
				2'd1: begin
					h1_x_q    <= item.is_x;
					h1_zero_q <= item.is_zero;
				end
				2'd2: begin
					h2_x_q <= item.is_x;
				end
				default: begin
				end
			endcase
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= pop_end;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_end) begin
			num_q <= num_nxt;
			err_q <= err_nxt;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OUT_W-NUM_W-ERR_W){1'b0}}, err_q, num_q};

`ifndef SYNTHESIS
	a_err_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (err_q == ERR_NONE) || (num_q == '0))
		else $error("nonzero value reported with an error code");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (err_q != 3'd7))
		else $error("undefined result code");

	a_beyond_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		beyond_q |-> (cnt_q == 2'd3))
		else $error("overflow flag set before three characters");

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		pop_end |=> (cnt_q == 2'd0) && (acc_q == '0) && !bad_q && !beyond_q)
		else $error("string state not cleared after end of string");

	a_end_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pop_end |=> out_vld_q)
		else $error("end of string produced no result");
`endif

endmodule

// ===== rtl/core/hex_text_to_integer_core.sv =====
// ----------------------------------------------------------------------------
// hex_text_to_integer_core
// Converts a stream of ASCII characters, closed by an end marker, into a
// signed 32-bit value and a result code.
// ----------------------------------------------------------------------------
// Input channel s_*: one transfer per character with s_tuser low and the
// code in s_tdata; a transfer with s_tuser high closes the string (s_tdata
// is then ignored). Output channel m_*: one transfer per closed string,
// number in m_tdata[31:0], result code in m_tdata[34:32]; characters give
// no output. Optional sign, optional 0x/0X prefix, digits 0-9 a-f A-F; the
// value wraps modulo 2^32 and is negated for a leading '-', and is zero
// whenever the code is nonzero.
// Throughput: one item per cycle on character transfers, and on end transfers
// while no result waits for m_tready; limited by the single shift-and-add in the back stage.
// The end transfer passes the front register, the queue and the output
// register before the result is offered.
// Reset clears the string state and both channels; no clearing pass.
// When m_tready is low the result holds, the two-entry queue and front
// register keep taking characters, and s_tready falls once they are full.
// ----------------------------------------------------------------------------
module hex_text_to_integer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // char_code[7:0]
	input  logic                        s_tuser,   // kind (1 = end of string)
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [htoi_pkg::OUT_W-1:0]  m_tdata    // number[31:0], error_code[34:32]
);
	import htoi_pkg::*;

	logic cls_vld;
	logic cls_rdy;
	cls_t cls;
	logic item_vld;
	logic item_rdy;
	cls_t item;

	// Accept and classify
	htoi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cls_vld  (cls_vld),
		.cls      (cls),
		.cls_rdy  (cls_rdy)
	);

	// Decouple front and back
	htoi_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_vld  (cls_vld),
		.push_rdy  (cls_rdy),
		.push_item (cls),
		.pop_vld   (item_vld),
		.pop_rdy   (item_rdy),
		.pop_item  (item)
	);

	// Accumulate and report
	htoi_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_vld (item_vld),
		.item_rdy (item_rdy),
		.item     (item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
